FILE: src/drpi_pkg.sv
// shared types, constants and helpers for the depth regulator piston integrator
// no dependencies
package drpi_pkg;

  localparam int unsigned SURFACE_LIMIT = 13107;
  localparam int unsigned TAN_ONE_Q16   = 102066;
  localparam int unsigned CORDIC_STEPS  = 24;
  localparam int unsigned ZW            = 28;
  localparam int unsigned MAW           = 40;
  localparam int unsigned MBW           = 22;
  localparam int unsigned PW            = MAW + MBW;

  // configuration register indexes
  localparam logic [2:0] REG_VELOCITY_GAIN   = 3'd0;
  localparam logic [2:0] REG_COMMAND_GAIN    = 3'd1;
  localparam logic [2:0] REG_FIELD_SPEED     = 3'd2;
  localparam logic [2:0] REG_APPROACH_THR    = 3'd3;
  localparam logic [2:0] REG_HYSTERESIS      = 3'd4;
  localparam logic [2:0] REG_FOLLOWING_LIMIT = 3'd5;
  localparam logic [2:0] REG_EQUILIBRIUM     = 3'd6;
  localparam logic [2:0] REG_COMPRESSIBILITY = 3'd7;

  typedef enum logic [17:0] {
    ST_IDLE   = 18'b000000000000000001,
    ST_MOFF   = 18'b000000000000000010,
    ST_OFFSET = 18'b000000000000000100,
    ST_MNUM   = 18'b000000000000001000,
    ST_DLOAD  = 18'b000000000000010000,
    ST_DIV    = 18'b000000000000100000,
    ST_CINIT  = 18'b000000000001000000,
    ST_CRUN   = 18'b000000000010000000,
    ST_MINT   = 18'b000000000100000000,
    ST_INTW   = 18'b000000001000000000,
    ST_MVEL   = 18'b000000010000000000,
    ST_VELW   = 18'b000000100000000000,
    ST_MERR   = 18'b000001000000000000,
    ST_MG1    = 18'b000010000000000000,
    ST_RATE   = 18'b000100000000000000,
    ST_MG2    = 18'b001000000000000000,
    ST_UPD    = 18'b010000000000000000,
    ST_OUT    = 18'b100000000000000000
  } state_t;

  // arctangent of 2^-i in Q24 rad
  function automatic logic signed [ZW-1:0] angle_step(input logic [4:0] i);
    logic signed [ZW-1:0] r;
    unique case (i)
      5'd0:  r = 28'sd13176795;
      5'd1:  r = 28'sd7778716;
      5'd2:  r = 28'sd4110060;
      5'd3:  r = 28'sd2086331;
      5'd4:  r = 28'sd1047214;
      5'd5:  r = 28'sd524117;
      5'd6:  r = 28'sd262123;
      5'd7:  r = 28'sd131069;
      5'd8:  r = 28'sd65536;
      5'd9:  r = 28'sd32768;
      5'd10: r = 28'sd16384;
      5'd11: r = 28'sd8192;
      5'd12: r = 28'sd4096;
      5'd13: r = 28'sd2048;
      5'd14: r = 28'sd1024;
      5'd15: r = 28'sd512;
      5'd16: r = 28'sd256;
      5'd17: r = 28'sd128;
      5'd18: r = 28'sd64;
      5'd19: r = 28'sd32;
      5'd20: r = 28'sd16;
      5'd21: r = 28'sd8;
      5'd22: r = 28'sd4;
      5'd23: r = 28'sd2;
      default: r = '0;
    endcase
    return r;
  endfunction

  // saturate to 40-bit signed
  function automatic logic signed [39:0] sat40(input logic signed [45:0] v);
    logic signed [45:0] hi;
    logic signed [45:0] lo;
    hi = 46'sh0_007F_FFFF_FFFF;
    lo = -hi - 46'sd1;
    if (v > hi) return hi[39:0];
    if (v < lo) return lo[39:0];
    return v[39:0];
  endfunction

endpackage

FILE: src/depth_regulator_piston_integrator.sv
// depth regulator piston integrator: one control tick per item, shared multiplier and cordic
// Per item: surface items go straight to the output; regulating items with saturated target
//   speed or zero error skip the divider and cordic; otherwise the divider runs, then one cordic
//   run at the table end, or two runs on the arctangent profile.
// Throughput: one item at a time; the input stalls until the result is taken.
// Reset (rst, synchronous): sequencer idle, configuration to defaults, integrator, set point and last command zero.
module depth_regulator_piston_integrator
  import drpi_pkg::*;
#(
  parameter int unsigned ATAN_TABLE_DEPTH = 256
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic signed [23:0] depth_now,
  input  logic signed [19:0] vertical_speed,
  input  logic        [15:0] piston_actual,
  input  logic               switch_inner,
  input  logic               switch_outer,
  input  logic        [22:0] target_depth,
  input  logic               mission_on,
  input  logic               emergency_on,
  input  logic        [19:0] elapsed_time,
  output logic               out_valid,
  input  logic               out_stall,
  output logic        [15:0] piston_command,
  output logic               windup_blocked,
  output logic               regulating,
  input  logic               cfg_write,
  input  logic        [2:0]  cfg_index,
  input  logic        [24:0] cfg_data
);

  localparam int unsigned DW = $clog2(ATAN_TABLE_DEPTH);
  localparam int unsigned IW = DW + 1;
  localparam int unsigned QW = DW + 17;
  localparam int unsigned CW = DW + 22;
  localparam logic [IW-1:0] DEPTH_I = IW'(ATAN_TABLE_DEPTH);

  // configuration registers
  logic        [15:0] velocity_gain, command_gain, field_speed, hysteresis_band;
  logic        [15:0] compressibility_gain;
  logic        [22:0] approach_threshold;
  logic        [19:0] following_limit;
  logic signed [24:0] equilibrium_offset;

  always_ff @(posedge clk) begin
    if (rst) begin
      velocity_gain        <= 16'd256;
      command_gain         <= 16'd200;
      field_speed          <= 16'd1311;
      approach_threshold   <= 23'd131072;
      hysteresis_band      <= 16'd154;
      following_limit      <= 20'd2560;
      equilibrium_offset   <= '0;
      compressibility_gain <= 16'd2560;
    end else if (cfg_write) begin
      unique case (cfg_index)
        REG_VELOCITY_GAIN:   velocity_gain        <= cfg_data[15:0];
        REG_COMMAND_GAIN:    command_gain         <= cfg_data[15:0];
        REG_FIELD_SPEED:     field_speed          <= cfg_data[15:0];
        REG_APPROACH_THR:    approach_threshold   <= cfg_data[22:0];
        REG_HYSTERESIS:      hysteresis_band      <= cfg_data[15:0];
        REG_FOLLOWING_LIMIT: following_limit      <= cfg_data[19:0];
        REG_EQUILIBRIUM:     equilibrium_offset   <= $signed(cfg_data);
        REG_COMPRESSIBILITY: compressibility_gain <= cfg_data[15:0];
        default: ;
      endcase
    end
  end

  // captured item
  logic signed [23:0] depth;
  logic signed [19:0] speed;
  logic        [15:0] piston;
  logic               sw_in, sw_out;
  logic        [19:0] dt;

  // state
  state_t state;
  logic signed [39:0] integrator, applied_sp;
  logic               at_surface;
  logic        [15:0] last_command;

  // working registers
  logic signed [PW-1:0] prod;
  logic signed [26:0]   offset;
  logic        [22:0]   mag;
  logic                 esign;
  logic        [23:0]   rem;
  logic        [QW-1:0] nsh, quo;
  logic        [5:0]    cnt;
  logic        [IW-1:0] idx, pnode;
  logic        [15:0]   frac;
  logic                 single, phase;
  logic signed [CW-1:0] cx, cy;
  logic signed [ZW-1:0] cz, n0, n1, ang;
  logic signed [17:0]   vsig;
  logic signed [39:0]   rate;

  assign in_stall = (state != ST_IDLE);

  // shared multiplier operand select
  logic signed [MAW-1:0] mul_a;
  logic signed [MBW-1:0] mul_b;
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    unique case (state)
      ST_MOFF: begin
        mul_a = MAW'(depth);
        mul_b = $signed({6'b0, compressibility_gain});
      end
      ST_MNUM: begin
        mul_a = $signed({17'b0, mag});
        mul_b = $signed(MBW'(ATAN_TABLE_DEPTH));
      end
      ST_MINT: begin
        mul_a = MAW'(n1 - n0);
        mul_b = $signed({6'b0, frac});
      end
      ST_MVEL: begin
        mul_a = MAW'(ang);
        mul_b = $signed({6'b0, field_speed});
      end
      ST_MERR: begin
        mul_a = MAW'(vsig) - MAW'(speed);
        mul_b = $signed({6'b0, velocity_gain});
      end
      ST_MG1: begin
        mul_a = prod[MAW-1:0];
        mul_b = $signed({6'b0, command_gain});
      end
      ST_MG2: begin
        mul_a = rate;
        mul_b = $signed({2'b0, dt});
      end
      default: ;
    endcase
  end

  // rounded shifts of the product
  logic signed [PW-1:0] prod_r16, prod_r24;
  assign prod_r16 = prod + PW'(32768);
  assign prod_r24 = prod + PW'(8388608);

  // set point of the captured item
  logic [22:0] mission_sp;
  logic        sp_latched_mission;
  logic [22:0] sp_latched;
  assign mission_sp = sp_latched_mission ? sp_latched : 23'd0;

  // depth error and its magnitude
  logic signed [25:0] err_e;
  logic        [24:0] err_mag;
  assign err_e   = $signed({3'b0, (mission_sp)}) - 26'(depth);
  assign err_mag = err_e[25] ? 25'(-err_e) : err_e[24:0];

  // divider step
  logic [23:0] div_t;
  logic        div_ge;
  assign div_t  = {rem[22:0], nsh[QW-1]};
  assign div_ge = (div_t >= {1'b0, approach_threshold});

  // cordic step
  logic signed [CW-1:0] xs, ys, y_init;
  assign xs     = cx >>> cnt[4:0];
  assign ys     = cy >>> cnt[4:0];
  assign y_init = $signed(CW'(pnode) * CW'(TAN_ONE_Q16));

  // update arithmetic
  logic signed [45:0] u_inc;
  logic signed [39:0] integ_new, set_new;
  logic signed [41:0] pos, e_old_s, e_new_s;
  logic        [41:0] e_old, e_new;
  logic               blocked;
  logic signed [40:0] cmd_round;
  logic        [15:0] cmd_sat;
  always_comb begin
    u_inc     = prod_r16[61:16];
    integ_new = sat40(46'(integrator) + u_inc);
    set_new   = sat40(46'(integ_new) + 46'(offset));
    pos       = $signed({18'b0, piston, 8'b0});
    e_old_s   = 42'(applied_sp) - pos;
    e_new_s   = 42'(set_new) - pos;
    e_old     = e_old_s[41] ? 42'(-e_old_s) : e_old_s;
    e_new     = e_new_s[41] ? 42'(-e_new_s) : e_new_s;
    blocked   = ((e_old > 42'(following_limit)) && (e_new > e_old) && !at_surface) ||
                (sw_out && (42'(set_new) < pos)) || (sw_in && (42'(set_new) > pos));
    cmd_round = (41'(set_new) + 41'sd128) >>> 8;
    if (set_new < 0) cmd_sat = '0;
    else if (cmd_round > 41'sd65535) cmd_sat = 16'hFFFF;
    else cmd_sat = cmd_round[15:0];
  end

  logic regulate_in;
  assign regulate_in = ((mission_on ? target_depth : 23'd0) > 23'(SURFACE_LIMIT)) &&
                       !emergency_on;

  // sequencer
  always_ff @(posedge clk) begin
    prod <= mul_a * mul_b;
    if (rst) begin
      state          <= ST_IDLE;
      integrator     <= '0;
      applied_sp     <= '0;
      at_surface     <= 1'b1;
      last_command   <= '0;
      out_valid      <= 1'b0;
    end else begin
      unique case (state)
        ST_IDLE: begin
          if (in_valid) begin
            depth              <= depth_now;
            speed              <= vertical_speed;
            piston             <= piston_actual;
            sw_in              <= switch_inner;
            sw_out             <= switch_outer;
            sp_latched         <= target_depth;
            sp_latched_mission <= mission_on;
            dt                 <= elapsed_time;
            if (regulate_in) begin
              state <= ST_MOFF;
            end else begin
              last_command   <= '0;
              at_surface     <= 1'b1;
              piston_command <= '0;
              windup_blocked <= 1'b0;
              regulating     <= 1'b0;
              out_valid      <= 1'b1;
              state          <= ST_OUT;
            end
          end
        end
        ST_MOFF: state <= ST_OFFSET;
        ST_OFFSET: begin
          offset <= 27'(equilibrium_offset) + 27'(prod_r16[61:16]);
          esign  <= err_e[25];
          mag    <= err_mag[22:0];
          if (err_mag > 25'(approach_threshold)) begin
            vsig  <= err_e[25] ? -18'(field_speed) : 18'(field_speed);
            state <= ST_MERR;
          end else if (err_mag == '0) begin
            vsig  <= '0;
            state <= ST_MERR;
          end else begin
            state <= ST_MNUM;
          end
        end
        ST_MNUM: state <= ST_DLOAD;
        ST_DLOAD: begin
          rem   <= 24'(prod[PW-1:QW-16]);
          nsh   <= {prod[DW:0], 16'b0};
          cnt   <= '0;
          state <= ST_DIV;
        end
        ST_DIV: begin
          rem <= div_ge ? (div_t - {1'b0, approach_threshold}) : div_t;
          quo <= {quo[QW-2:0], div_ge};
          nsh <= {nsh[QW-2:0], 1'b0};
          cnt <= cnt + 6'd1;
          if (cnt == 6'(QW - 1)) begin
            state <= ST_CINIT;
          end
        end
        ST_CINIT: begin
          if (cnt != '0) begin
            // first entry after the divider
            idx   <= quo[QW-1:16];
            frac  <= quo[15:0];
            phase <= 1'b0;
            if (quo[QW-1:16] >= DEPTH_I) begin
              single <= 1'b1;
              pnode  <= DEPTH_I;
            end else begin
              single <= 1'b0;
              pnode  <= quo[QW-1:16];
            end
            cnt <= '0;
          end else begin
            cx  <= $signed(CW'(ATAN_TABLE_DEPTH) << 16);
            cy  <= y_init;
            cz  <= '0;
            state <= ST_CRUN;
          end
        end
        ST_CRUN: begin
          if (pnode != '0) begin
            if (cy >= 0) begin
              cx <= cx + ys;
              cy <= cy - xs;
              cz <= cz + angle_step(cnt[4:0]);
            end else begin
              cx <= cx - ys;
              cy <= cy + xs;
              cz <= cz - angle_step(cnt[4:0]);
            end
          end
          if (cnt == 6'(CORDIC_STEPS)) begin
            cnt <= '0;
            if (single) begin
              ang   <= cz;
              state <= ST_MVEL;
            end else if (!phase) begin
              n0    <= cz;
              phase <= 1'b1;
              pnode <= idx + IW'(1);
              state <= ST_CINIT;
            end else begin
              n1    <= cz;
              state <= ST_MINT;
            end
          end else begin
            cnt <= cnt + 6'd1;
          end
        end
        ST_MINT: state <= ST_INTW;
        ST_INTW: begin
          ang   <= n0 + ZW'(prod >>> 16);
          state <= ST_MVEL;
        end
        ST_MVEL: state <= ST_VELW;
        ST_VELW: begin
          vsig  <= esign ? -18'(prod_r24[40:24]) : 18'(prod_r24[40:24]);
          state <= ST_MERR;
        end
        ST_MERR: state <= ST_MG1;
        ST_MG1:  state <= ST_RATE;
        ST_RATE: begin
          rate  <= prod_r16[55:16];
          state <= ST_MG2;
        end
        ST_MG2: state <= ST_UPD;
        ST_UPD: begin
          if (!blocked) begin
            integrator <= integ_new;
            applied_sp <= set_new;
            if (e_new > 42'(hysteresis_band)) begin
              last_command <= cmd_sat;
            end
          end
          piston_command <= (!blocked && (e_new > 42'(hysteresis_band))) ? cmd_sat
                                                                          : last_command;
          windup_blocked <= blocked;
          regulating     <= 1'b1;
          at_surface     <= 1'b0;
          out_valid      <= 1'b1;
          state          <= ST_OUT;
        end
        ST_OUT: begin
          if (!out_stall) begin
            out_valid <= 1'b0;
            state     <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

endmodule
